/* design/csort_pkg.sv */
// Shared types and constants of the counting sort engine.
`default_nettype none

package csort_pkg;

    localparam int VAL_W           = 11;
    localparam int LIM_W           = 12;
    localparam int DROP_W          = 8;
    localparam int MAX_ITEMS_DEF   = 64;
    localparam int VALUE_RANGE_DEF = 2048;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 12'd2048;
    localparam logic [DROP_W-1:0] DROP_SAT   = 8'hFF;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_INC,
        ST_RD,
        ST_CHK,
        ST_EMIT,
        ST_EMPTY
    } t_state;

    // One result beat handed from the sequencer to the output register.
    typedef struct packed {
        logic              load;
        logic [VAL_W-1:0]  value;
        logic              run_end;
        logic              empty;
        logic [DROP_W-1:0] dropped;
    } t_emit;

endpackage

`default_nettype wire

/* design/csort_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/csort_ctrl.sv */
// Sequencer of the counting sort: histogram update, bin sweep and result issue.
`default_nettype none

module csort_ctrl
    import csort_pkg::*;
#(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int VALUE_RANGE = VALUE_RANGE_DEF,
    parameter int IDX_W       = $clog2(VALUE_RANGE),
    parameter int CNT_W       = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [VAL_W-1:0] i_in_value,
    input  wire logic             i_in_final,
    input  wire logic             i_cfg_valid,
    input  wire logic [LIM_W-1:0] i_cfg_data,
    input  wire logic             i_out_free,
    output t_emit                 o_emit,
    output logic                  o_ram_we,
    output logic      [IDX_W-1:0] o_ram_waddr,
    output logic      [CNT_W-1:0] o_ram_wdata,
    output logic      [IDX_W-1:0] o_ram_raddr,
    input  wire logic [CNT_W-1:0] i_ram_rdata
);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_val, n_val;
    logic [CNT_W-1:0]   r_kept, n_kept;
    logic [CNT_W-1:0]   r_emit, n_emit;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [DROP_W-1:0]  r_drop, n_drop;
    logic               r_fin, n_fin;
    logic [LIM_W-1:0]   r_limit;

    logic [VAL_W+IDX_W-1:0] w_in_wide;
    logic [VAL_W+IDX_W-1:0] w_val_wide;
    logic [IDX_W-1:0]       w_in_idx;
    logic                   w_acc;
    logic                   w_keep;

    assign w_in_wide  = (VAL_W + IDX_W)'(i_in_value);
    assign w_in_idx   = w_in_wide[IDX_W-1:0];
    assign w_val_wide = (VAL_W + IDX_W)'(r_val);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_keep     = ({1'b0, i_in_value} < r_limit)
                        && (32'(i_in_value) < 32'(VALUE_RANGE))
                        && (r_kept < CNT_W'(MAX_ITEMS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_idx   <= '0;
            r_kept  <= '0;
            r_emit  <= '0;
            r_drop  <= '0;
            r_fin   <= 1'b0;
            r_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_kept  <= n_kept;
            r_emit  <= n_emit;
            r_drop  <= n_drop;
            r_fin   <= n_fin;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_left <= n_left;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_val       = r_val;
        n_kept      = r_kept;
        n_emit      = r_emit;
        n_left      = r_left;
        n_drop      = r_drop;
        n_fin       = r_fin;
        o_in_ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        o_ram_wdata = '0;
        o_ram_raddr = r_idx;
        o_emit      = '0;
        case (r_state)
            ST_CLR: begin
                o_ram_we = 1'b1;
                n_idx    = r_idx + 1'b1;
                if (r_idx == IDX_W'(VALUE_RANGE - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ram_raddr = w_in_idx;
                if (w_acc) begin
                    n_idx = '0;
                    if (w_keep) begin
                        n_kept  = r_kept + 1'b1;
                        n_val   = w_in_idx;
                        n_fin   = i_in_final;
                        n_state = ST_INC;
                    end else begin
                        if (r_drop != DROP_SAT) begin
                            n_drop = r_drop + 1'b1;
                        end
                        if (i_in_final) begin
                            n_state = (r_kept == '0) ? ST_EMPTY : ST_RD;
                        end
                    end
                end
            end
            ST_INC: begin
                // The bin was read in the accept cycle; write back one more.
                o_ram_we    = 1'b1;
                o_ram_waddr = r_val;
                o_ram_wdata = i_ram_rdata + 1'b1;
                n_state     = r_fin ? ST_RD : ST_IDLE;
            end
            ST_RD: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                // Look ahead at the next bin while this one is examined.
                o_ram_raddr = r_idx + 1'b1;
                n_idx       = r_idx + 1'b1;
                if (i_ram_rdata != '0) begin
                    o_ram_we = 1'b1;
                    n_val    = r_idx;
                    n_left   = i_ram_rdata;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_emit.load  = 1'b1;
                    o_emit.value = w_val_wide[VAL_W-1:0];
                    n_left       = r_left - 1'b1;
                    n_emit       = r_emit + 1'b1;
                    if (r_emit + 1'b1 == r_kept) begin
                        o_emit.run_end = 1'b1;
                        o_emit.dropped = r_drop;
                        n_kept         = '0;
                        n_emit         = '0;
                        n_drop         = '0;
                        n_state        = ST_IDLE;
                    end else if (r_left == CNT_W'(1)) begin
                        n_state = ST_CHK;
                    end
                end
            end
            ST_EMPTY: begin
                if (i_out_free) begin
                    o_emit.load    = 1'b1;
                    o_emit.run_end = 1'b1;
                    o_emit.empty   = 1'b1;
                    o_emit.dropped = r_drop;
                    n_drop         = '0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= CNT_W'(MAX_ITEMS))
        else $error("kept count beyond store capacity");

    a_emit_below_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_emit < r_kept && r_left != '0))
        else $error("emission beyond the kept items");

    a_empty_only_unkept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.load && o_emit.empty) |-> (r_kept == '0))
        else $error("empty result while items are kept");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.load |-> i_out_free)
        else $error("result issued into a busy output register");

endmodule

`default_nettype wire

/* design/counting_sort_engine.sv */
// Top level of the counting sort engine: sequencer, bin RAM and output register.
`default_nettype none

// Values arrive one beat at a time and are counted into a bin RAM of
// VALUE_RANGE entries; a kept value's bin is read, then written back with
// the incremented count, and a dropped one is only tallied. When the beat
// marked tlast is taken, the sequencer sweeps the bins upward from zero,
// clearing each nonzero bin as it reads it and issuing one result per
// counted item, and it stops after the last kept item. s_axis_tready
// stays low during the sweep. After reset the bin RAM is cleared in a
// pass over all VALUE_RANGE entries before the first beat is taken. The
// value limit register may be written at any time the block is idle.
module counting_sort_engine
    import csort_pkg::*;
#(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int VALUE_RANGE = VALUE_RANGE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [10:0] item_value, [15:11] zero
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    input  wire logic                s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [10:0] sorted_value, [18:11] dropped_count, [23:19] zero
    output logic      [M_DATA_W-1:0] m_axis_tdata,
    // [0] empty_set
    output logic                     m_axis_tuser,
    output logic                     m_axis_tlast,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [LIM_W-1:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(VALUE_RANGE);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    t_emit              w_emit;
    logic               w_out_free;
    logic               w_ram_we;
    logic [IDX_W-1:0]   w_ram_waddr;
    logic [CNT_W-1:0]   w_ram_wdata;
    logic [IDX_W-1:0]   w_ram_raddr;
    logic [CNT_W-1:0]   w_ram_rdata;

    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_value;
    logic [DROP_W-1:0]  r_out_dropped;
    logic               r_out_empty;
    logic               r_out_last;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || m_axis_tready;

    csort_ctrl #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_RANGE (VALUE_RANGE),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_value  (s_axis_tdata[VAL_W-1:0]),
        .i_in_final  (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (w_out_free),
        .o_emit      (w_emit),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    csort_ram #(
        .WIDTH (CNT_W),
        .DEPTH (VALUE_RANGE)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Output register: holds one result beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.load) begin
            r_out_value   <= w_emit.value;
            r_out_dropped <= w_emit.dropped;
            r_out_empty   <= w_emit.empty;
            r_out_last    <= w_emit.run_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W - VAL_W - DROP_W){1'b0}}, r_out_dropped, r_out_value};
    assign m_axis_tuser  = r_out_empty;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the counting sort engine: directed table, then random sets.
`default_nettype none

module tb_top;
    import csort_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 2;
    localparam int SET_MAX_LEN   = 4;
    // Fills the store with 64 beats, then drops 256 more to pin the tally at 255.
    localparam int SAT_SET_ITEMS = 320;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic              run_end;
        logic              empty;
        logic [DROP_W-1:0] dropped;
    } t_sorted_beat;

    typedef enum logic {ROW_ITEM, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [LIM_W-1:0] arg;
        logic             last;
        logic             typed;
        t_sorted_beat     want;
    } t_dir_row;

    localparam t_sorted_beat NO_BEAT = '0;

    // Rows with typed set carry the single result of a set that is obvious
    // by eye; all other sets are checked against the sort predictor.
    t_dir_row dir_rows [0:24] = '{
        '{ROW_ITEM,  12'd0,    1'b1, 1'b1, '{11'd0,    1'b1, 1'b0, 8'd0}},
        '{ROW_ITEM,  12'd2047, 1'b1, 1'b1, '{11'd2047, 1'b1, 1'b0, 8'd0}},
        '{ROW_ITEM,  12'd5,    1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd3,    1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd2047, 1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd0,    1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd3,    1'b1, 1'b0, NO_BEAT},
        '{ROW_LIMIT, 12'd0,    1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd7,    1'b1, 1'b1, '{11'd0,    1'b1, 1'b1, 8'd1}},
        '{ROW_ITEM,  12'd0,    1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd2047, 1'b1, 1'b1, '{11'd0,    1'b1, 1'b1, 8'd2}},
        '{ROW_LIMIT, 12'd1,    1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd1,    1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd0,    1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd0,    1'b1, 1'b0, NO_BEAT},
        // The final beat is out of range, yet the sort still runs.
        '{ROW_ITEM,  12'd0,    1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd5,    1'b1, 1'b1, '{11'd0,    1'b1, 1'b0, 8'd1}},
        '{ROW_LIMIT, 12'd4095, 1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd2047, 1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd1024, 1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd1,    1'b1, 1'b0, NO_BEAT},
        '{ROW_LIMIT, 12'd1024, 1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd1023, 1'b0, 1'b0, NO_BEAT},
        '{ROW_ITEM,  12'd1024, 1'b1, 1'b1, '{11'd1023, 1'b1, 1'b0, 8'd1}},
        '{ROW_LIMIT, 12'd2048, 1'b0, 1'b0, NO_BEAT}
    };

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [LIM_W-1:0]    i_cfg_data    = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count = 0;

    // Predictor state: the current limit, the values kept so far in this set
    // and the saturating drop tally.
    logic [LIM_W-1:0]  model_limit = LIMIT_RESET;
    logic [VAL_W-1:0]  kept_vals [MAX_ITEMS_DEF];
    int unsigned       kept_n = 0;
    logic [DROP_W-1:0] drop_tally = '0;

    t_sorted_beat run_results [$];
    t_sorted_beat sorted_expected [$];

    counting_sort_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // Takes one accepted value into the set; on the final beat it sorts the
    // kept values and queues one result per value, or the empty-set result.
    task automatic count_sort_accept(input logic [VAL_W-1:0] v, input logic last);
        t_sorted_beat beat;
        logic [VAL_W-1:0] key;
        int j;
        if ({1'b0, v} < model_limit && kept_n < MAX_ITEMS_DEF) begin
            kept_vals[kept_n] = v;
            kept_n++;
        end else if (drop_tally != DROP_SAT) begin
            drop_tally++;
        end
        if (!last)
            return;
        if (kept_n == 0) begin
            beat = '{value: '0, run_end: 1'b1, empty: 1'b1, dropped: drop_tally};
            run_results.push_back(beat);
        end else begin
            for (int i = 1; i < kept_n; i++) begin
                key = kept_vals[i];
                j = i - 1;
                while (j >= 0 && kept_vals[j] > key) begin
                    kept_vals[j + 1] = kept_vals[j];
                    j--;
                end
                kept_vals[j + 1] = key;
            end
            for (int i = 0; i < kept_n; i++) begin
                beat.value   = kept_vals[i];
                beat.run_end = (i + 1 == kept_n);
                beat.empty   = 1'b0;
                beat.dropped = (i + 1 == kept_n) ? drop_tally : '0;
                run_results.push_back(beat);
            end
        end
        kept_n = 0;
        drop_tally = '0;
    endtask

    task automatic send_item(input logic [VAL_W-1:0] v, input logic last,
                             input logic typed, input t_sorted_beat want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - VAL_W){1'b0}}, v};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        count_sort_accept(v, last);
        if (typed) begin
            run_results.delete();
            sorted_expected.push_back(want);
        end else begin
            while (run_results.size() != 0)
                sorted_expected.push_back(run_results.pop_front());
        end
    endtask

    // Waits until the last expected beat is out and the sweep has wound down.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sorted_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_limit = lim;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned span;
        int unsigned r;
        span = (model_limit == 0 || model_limit > VALUE_RANGE_DEF) ?
               VALUE_RANGE_DEF : model_limit;
        r = $urandom_range(99);
        if (r < 80)
            return VAL_W'($urandom_range(span - 1, 0));
        if (r < 90 && span < VALUE_RANGE_DEF)
            return VAL_W'($urandom_range(1) ? span : span - 1);
        return VAL_W'($urandom_range(VALUE_RANGE_DEF - 1, 0));
    endfunction

    always @(posedge i_clk) begin : result_check
        t_sorted_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sorted_expected.size() == 0) begin
                $error("unexpected result beat: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = sorted_expected.pop_front();
                if (m_axis_tdata[VAL_W-1:0] !== want.value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.value, m_axis_tdata[VAL_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[VAL_W+DROP_W-1:VAL_W] !== want.dropped) begin
                    $error("dropped_count: expected %0d, got %0d",
                           want.dropped, m_axis_tdata[VAL_W+DROP_W-1:VAL_W]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.empty) begin
                    $error("empty_set: expected %0b, got %0b", want.empty, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tlast !== want.run_end) begin
                    $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tlast);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        int unsigned phase_items;
        int unsigned set_len;
        int unsigned shape;
        logic [LIM_W-1:0] phase_limits [8];

        phase_limits = '{12'd2048, 12'd2047, 12'd1, 12'd4095,
                         LIM_W'($urandom_range(2048, 1)), 12'd0, 12'd3,
                         LIM_W'($urandom_range(2048, 1))};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_LIMIT) begin
                wait_until_drained();
                write_limit(dir_rows[i].arg);
            end else begin
                send_item(dir_rows[i].arg[VAL_W-1:0], dir_rows[i].last,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            wait_until_drained();
            write_limit(phase_limits[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase

            // One very long set overflows the store and saturates the tally.
            if (phase == 3) begin
                for (int k = 0; k < SAT_SET_ITEMS; k++)
                    send_item(pick_value(), k == SAT_SET_ITEMS - 1, 1'b0, NO_BEAT);
            end

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                shape = $urandom_range(99);
                set_len = $urandom_range(SET_MAX_LEN, 1);
                for (int k = 0; k < set_len; k++) begin
                    if (shape < 20)
                        send_item(VAL_W'($urandom_range(VALUE_RANGE_DEF - 1, 0)),
                                  k == set_len - 1, 1'b0, NO_BEAT);
                    else
                        send_item(pick_value(), k == set_len - 1, 1'b0, NO_BEAT);
                end
                phase_items += set_len;
            end
        end

        wait_until_drained();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
